### hdl/i2cts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cts_pkg: shared types and constants of the I2C transaction sequencer
// Sizes of the descriptor table and transmit store, bus command and TWI status
// codes, the transfer payloads and the controller/datapath command struct.
// ----------------------------------------------------------------------------
package i2cts_pkg;

	localparam int MAX_MSGS = 4;
	localparam int MAX_LEN  = 32;

	localparam int MSG_W      = $clog2(MAX_MSGS);
	localparam int BYTE_W     = $clog2(MAX_LEN);
	localparam int MSG_CNT_W  = $clog2(MAX_MSGS + 1);
	localparam int LEN_W      = $clog2(MAX_LEN + 1);
	localparam int TX_DEPTH   = MAX_MSGS * MAX_LEN;
	localparam int TX_AW      = $clog2(TX_DEPTH);

	typedef enum logic [1:0] {
		ACT_LOAD_DESC = 2'd0,
		ACT_LOAD_TX   = 2'd1,
		ACT_BEGIN     = 2'd2,
		ACT_EVENT     = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_ACK   = 3'd2,
		CMD_NACK  = 3'd3,
		CMD_STOP  = 3'd4
	} bus_cmd_t;

	// TWI status codes with the prescaler bits masked.
	localparam logic [7:0] TWS_START         = 8'h08;
	localparam logic [7:0] TWS_REP_START     = 8'h10;
	localparam logic [7:0] TWS_MT_SLA_ACK    = 8'h18;
	localparam logic [7:0] TWS_MT_DATA_ACK   = 8'h28;
	localparam logic [7:0] TWS_ARB_LOST      = 8'h38;
	localparam logic [7:0] TWS_MR_SLA_ACK    = 8'h40;
	localparam logic [7:0] TWS_MR_DATA_ACK   = 8'h50;
	localparam logic [7:0] TWS_MR_DATA_NACK  = 8'h58;
	localparam logic [7:0] DONE_OK           = 8'h00;

	typedef struct packed {
		action_t     action;
		logic [1:0]  msg_sel;
		logic [4:0]  byte_sel;
		logic [7:0]  addr_byte;
		logic [5:0]  msg_len;
		logic [7:0]  data_byte;
		logic [2:0]  msg_count;
		logic [7:0]  status_code;
		logic [7:0]  rx_data;
	} req_item_t;

	typedef struct packed {
		bus_cmd_t    bus_command;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        rx_valid;
		logic [1:0]  rx_msg;
		logic [4:0]  rx_index;
		logic [7:0]  rx_value;
		logic        done_res;
		logic [7:0]  done_status;
		logic        refused;
	} rsp_item_t;

	typedef enum logic {
		CS_IDLE = 1'b0,
		CS_EVAL = 1'b1
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic eval;
	} dp_cmd_t;

endpackage

### hdl/i2cts_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cts_req_if: request channel of the I2C transaction sequencer
// Valid/ready channel carrying one request item per transfer.
// ----------------------------------------------------------------------------
interface i2cts_req_if;
	logic                  valid;
	logic                  ready;
	i2cts_pkg::req_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### hdl/i2cts_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cts_rsp_if: result channel of the I2C transaction sequencer
// Valid/ready channel carrying one result item per transfer.
// ----------------------------------------------------------------------------
interface i2cts_rsp_if;
	logic                  valid;
	logic                  ready;
	i2cts_pkg::rsp_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### hdl/i2cts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cts_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module i2cts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/i2cts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cts_ctrl: controller of the I2C transaction sequencer
// Two-state machine that captures a request, lets the datapath evaluate it in
// the following cycle and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module i2cts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output i2cts_pkg::dp_cmd_t  cmd
);

	i2cts_pkg::ctrl_state_t state_q, state_d;
	logic                   rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2cts_pkg::CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		cmd.capture = 1'b0;
		cmd.eval    = 1'b0;
		case (state_q)
			i2cts_pkg::CS_IDLE: begin
				// The result register is free, or is emptied at this edge.
				req_ready   = !rsp_valid_q || rsp_ready;
				cmd.capture = req_valid && req_ready;
				if (cmd.capture) begin
					state_d = i2cts_pkg::CS_EVAL;
				end
			end
			i2cts_pkg::CS_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = i2cts_pkg::CS_IDLE;
			end
			default: begin
				state_d = i2cts_pkg::CS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.eval) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

`ifndef NO_ASSERTIONS
	a_eval_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == i2cts_pkg::CS_EVAL |-> !rsp_valid_q)
		else $error("evaluation would overwrite an untaken result");

	a_capture_then_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> ##1 rsp_valid_q)
		else $error("captured request produced no result");
`endif

endmodule

### hdl/i2cts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cts_dp: datapath of the I2C transaction sequencer
// Descriptor table, transmit byte store, sequencing registers and the result
// register; evaluates one captured request when the controller says so.
// ----------------------------------------------------------------------------
module i2cts_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  i2cts_pkg::dp_cmd_t    cmd,
	input  i2cts_pkg::req_item_t  req_item,
	output i2cts_pkg::rsp_item_t  rsp_item
);

	i2cts_pkg::req_item_t item_q;
	i2cts_pkg::rsp_item_t rsp_q, rsp_d;

	logic [7:0]                      desc_addr_q [i2cts_pkg::MAX_MSGS];
	logic [i2cts_pkg::LEN_W-1:0]     desc_len_q  [i2cts_pkg::MAX_MSGS];

	logic [i2cts_pkg::MSG_CNT_W-1:0] active_count_q, active_count_d;
	logic [i2cts_pkg::MSG_CNT_W-1:0] cur_msg_q, cur_msg_d;
	logic [i2cts_pkg::LEN_W-1:0]     cur_byte_q, cur_byte_d;
	logic                            pending_q, pending_d;

	logic [i2cts_pkg::MSG_W-1:0]     msg_now;
	logic [i2cts_pkg::BYTE_W-1:0]    byte_now;
	logic [i2cts_pkg::TX_AW-1:0]     rd_addr;
	logic [7:0]                      rd_data;
	logic                            tx_we;
	logic [i2cts_pkg::LEN_W-1:0]     len_sat;
	logic [i2cts_pkg::LEN_W-1:0]     len;

	// Slot in use; an out-of-range message counter falls back to slot zero.
	assign msg_now  = (cur_msg_q < i2cts_pkg::MSG_CNT_W'(i2cts_pkg::MAX_MSGS))
		? cur_msg_q[i2cts_pkg::MSG_W-1:0] : '0;
	assign byte_now = (req_item.status_code == i2cts_pkg::TWS_MT_SLA_ACK)
		? '0 : cur_byte_q[i2cts_pkg::BYTE_W-1:0];
	assign rd_addr  = {msg_now, byte_now};
	assign tx_we    = cmd.eval && (item_q.action == i2cts_pkg::ACT_LOAD_TX);
	assign len      = desc_len_q[msg_now];
	assign len_sat  = (item_q.msg_len > i2cts_pkg::LEN_W'(i2cts_pkg::MAX_LEN))
		? i2cts_pkg::LEN_W'(i2cts_pkg::MAX_LEN) : item_q.msg_len;

	i2cts_ram #(
		.WIDTH (8),
		.DEPTH (i2cts_pkg::TX_DEPTH)
	) u_tx_store (
		.clk   (clk),
		.we    (tx_we),
		.waddr ({item_q.msg_sel, item_q.byte_sel}),
		.wdata (item_q.data_byte),
		.re    (cmd.capture),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req_item;
		end
		if (cmd.eval) begin
			rsp_q <= rsp_d;
		end
		if (cmd.eval && item_q.action == i2cts_pkg::ACT_LOAD_DESC) begin
			desc_addr_q[item_q.msg_sel] <= item_q.addr_byte;
			desc_len_q[item_q.msg_sel]  <= len_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= '0;
			cur_msg_q      <= '0;
			cur_byte_q     <= '0;
			pending_q      <= 1'b0;
		end else if (cmd.eval) begin
			active_count_q <= active_count_d;
			cur_msg_q      <= cur_msg_d;
			cur_byte_q     <= cur_byte_d;
			pending_q      <= pending_d;
		end
	end

	always_comb begin
		logic                            do_next;
		logic                            do_finish;
		logic [7:0]                      fin_status;
		logic [i2cts_pkg::LEN_W:0]       nb;
		logic [i2cts_pkg::MSG_CNT_W:0]   nm;

		rsp_d          = '0;
		active_count_d = active_count_q;
		cur_msg_d      = cur_msg_q;
		cur_byte_d     = cur_byte_q;
		pending_d      = pending_q;
		do_next        = 1'b0;
		do_finish      = 1'b0;
		fin_status     = i2cts_pkg::DONE_OK;
		nb             = {1'b0, cur_byte_q} + 1'b1;
		nm             = {1'b0, cur_msg_q} + 1'b1;

		case (item_q.action)
			i2cts_pkg::ACT_BEGIN: begin
				if (pending_q) begin
					rsp_d.refused = 1'b1;
				end else begin
					if (item_q.msg_count == '0) begin
						active_count_d = i2cts_pkg::MSG_CNT_W'(1);
					end else if (item_q.msg_count >
						3'(i2cts_pkg::MAX_MSGS)) begin
						active_count_d = i2cts_pkg::MSG_CNT_W'(i2cts_pkg::MAX_MSGS);
					end else begin
						active_count_d = i2cts_pkg::MSG_CNT_W'(item_q.msg_count);
					end
					cur_msg_d         = '0;
					cur_byte_d        = '0;
					pending_d         = 1'b1;
					rsp_d.bus_command = i2cts_pkg::CMD_START;
				end
			end
			i2cts_pkg::ACT_EVENT: begin
				if (pending_q) begin
					// Received bytes are reported while the position fits.
					if (item_q.status_code == i2cts_pkg::TWS_MR_DATA_ACK ||
						item_q.status_code == i2cts_pkg::TWS_MR_DATA_NACK) begin
						rsp_d.rx_valid = cur_byte_q <
							i2cts_pkg::LEN_W'(i2cts_pkg::MAX_LEN);
						if (rsp_d.rx_valid) begin
							rsp_d.rx_msg   = msg_now;
							rsp_d.rx_index = cur_byte_q[i2cts_pkg::BYTE_W-1:0];
							rsp_d.rx_value = item_q.rx_data;
						end
					end
					case (item_q.status_code)
						i2cts_pkg::TWS_START, i2cts_pkg::TWS_REP_START: begin
							rsp_d.tx_valid    = 1'b1;
							rsp_d.tx_byte     = desc_addr_q[msg_now];
							rsp_d.bus_command = i2cts_pkg::CMD_ACK;
						end
						i2cts_pkg::TWS_MT_SLA_ACK: begin
							if (len != '0) begin
								rsp_d.tx_valid    = 1'b1;
								rsp_d.tx_byte     = rd_data;
								cur_byte_d        = i2cts_pkg::LEN_W'(1);
								rsp_d.bus_command = i2cts_pkg::CMD_ACK;
							end else begin
								do_next = 1'b1;
							end
						end
						i2cts_pkg::TWS_MT_DATA_ACK: begin
							if (cur_byte_q < len) begin
								rsp_d.tx_valid    = 1'b1;
								rsp_d.tx_byte     = rd_data;
								cur_byte_d        = nb[i2cts_pkg::LEN_W-1:0];
								rsp_d.bus_command = i2cts_pkg::CMD_ACK;
							end else begin
								do_next = 1'b1;
							end
						end
						i2cts_pkg::TWS_MR_SLA_ACK: begin
							// A one-byte read is acked here and so overreads.
							if (len != '0) begin
								rsp_d.bus_command = i2cts_pkg::CMD_ACK;
							end else begin
								do_next = 1'b1;
							end
						end
						i2cts_pkg::TWS_MR_DATA_ACK: begin
							cur_byte_d = nb[i2cts_pkg::LEN_W-1:0];
							if (len != '0 && nb == ({1'b0, len} - 1'b1)) begin
								rsp_d.bus_command = i2cts_pkg::CMD_NACK;
							end else if (nb >= {1'b0, len}) begin
								do_next = 1'b1;
							end else begin
								rsp_d.bus_command = i2cts_pkg::CMD_ACK;
							end
						end
						i2cts_pkg::TWS_MR_DATA_NACK: begin
							if (nb != {1'b0, len}) begin
								do_finish  = 1'b1;
								fin_status = i2cts_pkg::TWS_MR_DATA_NACK;
							end else begin
								do_next = 1'b1;
							end
						end
						i2cts_pkg::TWS_ARB_LOST: begin
							cur_byte_d        = '0;
							cur_msg_d         = '0;
							rsp_d.bus_command = i2cts_pkg::CMD_START;
						end
						default: begin
							// Slave NACK, bus error and unknown codes end it.
							do_finish  = 1'b1;
							fin_status = item_q.status_code;
						end
					endcase

					if (do_next) begin
						cur_byte_d = '0;
						if (nm < {1'b0, active_count_q}) begin
							cur_msg_d         = nm[i2cts_pkg::MSG_CNT_W-1:0];
							rsp_d.bus_command = i2cts_pkg::CMD_START;
						end else begin
							do_finish  = 1'b1;
							fin_status = i2cts_pkg::DONE_OK;
						end
					end
					if (do_finish) begin
						rsp_d.bus_command = i2cts_pkg::CMD_STOP;
						rsp_d.done_res    = 1'b1;
						rsp_d.done_status = fin_status;
						pending_d         = 1'b0;
						cur_msg_d         = '0;
						cur_byte_d        = '0;
					end
				end
			end
			default: begin
				// Loads are written by the clocked blocks; the result is empty.
			end
		endcase
	end

	assign rsp_item = rsp_q;

`ifndef NO_ASSERTIONS
	a_idle_counters_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!pending_q |-> (cur_msg_q == '0 && cur_byte_q == '0))
		else $error("sequencing counters left set while idle");

	a_done_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval && rsp_d.done_res |=> !pending_q)
		else $error("transaction finished but still pending");

	a_active_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (active_count_q != '0 &&
			active_count_q <= i2cts_pkg::MSG_CNT_W'(i2cts_pkg::MAX_MSGS)))
		else $error("message count out of range during a transaction");
`endif

endmodule

### hdl/i2c_master_transaction_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer: multi-message I2C master sequencer
// Top level joining the controller, the datapath and the channel interfaces.
// ----------------------------------------------------------------------------
// Usage:
// The req channel takes one item per transfer: a descriptor load, a transmit
// byte load, a begin request or a bus status event carrying a TWI status code
// and the byte read from the bus data register.
// Every request yields exactly one item on the rsp channel: the next bus
// command, a byte to transmit, a received byte with its slot and position,
// the completion flag with its status, or the refusal of a begin request.
// From the req transfer to rsp valid, a request is first captured, which
// also reads the transmit store, and then evaluated into the result register.
// No new request is taken while one is being evaluated, since the transmit
// store RAM has a registered read.
// A new request is taken while a result waits, provided that result is taken
// in the same cycle; a stalled rsp receiver holds the result and req ready
// goes low until it is taken.
// Reset clears the sequencing state and leaves no transaction pending. The
// descriptor table and transmit store hold no defined data until loaded.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	i2cts_req_if.sink   req,
	i2cts_rsp_if.source rsp
);

	i2cts_pkg::dp_cmd_t   cmd;
	i2cts_pkg::rsp_item_t rsp_item;

	// The controller sequences each transfer through capture and evaluation.
	i2cts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// The datapath holds the tables, the counters and the result register.
	i2cts_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_item (req.payload),
		.rsp_item (rsp_item)
	);

	assign rsp.payload = rsp_item;

endmodule

### sim/tb_i2c_master_transaction_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_transaction_sequencer: self-checking bench of the sequencer
// Drives descriptor and transmit loads, begin requests and TWI status events,
// mostly as a well-behaved bus would answer, mixed with stray and broken
// events. A scoreboard predicts every result and checks each rsp transfer.
// ----------------------------------------------------------------------------
module tb_i2c_master_transaction_sequencer;

	import i2cts_pkg::*;

	// Status codes that the sequencer does not decode; each one must stop the
	// transaction with that code as its status.
	localparam logic [7:0] TWS_BUS_ERROR     = 8'h00;
	localparam logic [7:0] TWS_START_LOWBIT  = 8'h09;
	localparam logic [7:0] TWS_MT_SLA_NACK   = 8'h20;
	localparam logic [7:0] TWS_MT_DATA_NACK  = 8'h30;
	localparam logic [7:0] TWS_MR_SLA_NACK   = 8'h48;

	localparam int TOTAL_ITEMS = 2000;

	// ------------------------------------------------------------------------
	// Scoreboard: keeps its own copy of the descriptor table, transmit store
	// and sequencing state, works out the result of every accepted request and
	// holds it until the matching rsp transfer arrives.
	// ------------------------------------------------------------------------
	class sequencer_scoreboard;
		logic [7:0]           desc_addr [MAX_MSGS];
		logic [LEN_W-1:0]     desc_len  [MAX_MSGS];
		logic [7:0]           tx_store  [TX_DEPTH];
		logic [MSG_CNT_W-1:0] active_count;
		logic [MSG_CNT_W-1:0] cur_msg;
		logic [LEN_W-1:0]     cur_byte;
		bit                   pending;
		rsp_item_t            awaited [$];
		int                   errors;

		function new();
			active_count = '0;
			cur_msg      = '0;
			cur_byte     = '0;
			pending      = 1'b0;
			errors       = 0;
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("[%0t] MISMATCH %s", $time, msg);
		endtask

		function void close_transaction(inout rsp_item_t o, input logic [7:0] code);
			o.bus_command = CMD_STOP;
			o.done_res    = 1'b1;
			o.done_status = code;
			pending       = 1'b0;
			cur_msg       = '0;
			cur_byte      = '0;
		endfunction

		function void advance_message(inout rsp_item_t o);
			cur_byte = '0;
			cur_msg++;
			if (cur_msg < active_count)
				o.bus_command = CMD_START;
			else
				close_transaction(o, DONE_OK);
		endfunction

		// A received byte is reported only while its position fits the store.
		function void take_byte(inout rsp_item_t o, input int m, input logic [7:0] v);
			if (int'(cur_byte) < MAX_LEN) begin
				o.rx_valid = 1'b1;
				o.rx_msg   = MSG_W'(m);
				o.rx_index = BYTE_W'(cur_byte);
				o.rx_value = v;
			end
			cur_byte++;
		endfunction

		function rsp_item_t predict_step(req_item_t r);
			rsp_item_t o;
			int m, len, cnt;
			o = '0;
			case (r.action)
				ACT_LOAD_DESC: begin
					desc_addr[r.msg_sel] = r.addr_byte;
					desc_len[r.msg_sel] = (int'(r.msg_len) > MAX_LEN) ? LEN_W'(MAX_LEN)
						: r.msg_len;
				end
				ACT_LOAD_TX: begin
					tx_store[int'(r.msg_sel) * MAX_LEN + int'(r.byte_sel)] = r.data_byte;
				end
				ACT_BEGIN: begin
					if (pending) begin
						o.refused = 1'b1;
					end else begin
						cnt = int'(r.msg_count);
						if (cnt < 1)
							cnt = 1;
						if (cnt > MAX_MSGS)
							cnt = MAX_MSGS;
						active_count  = MSG_CNT_W'(cnt);
						cur_msg       = '0;
						cur_byte      = '0;
						pending       = 1'b1;
						o.bus_command = CMD_START;
					end
				end
				default: begin
					if (pending) begin
						m = (int'(cur_msg) < MAX_MSGS) ? int'(cur_msg) : 0;
						len = int'(desc_len[m]);
						case (r.status_code)
							TWS_START, TWS_REP_START: begin
								o.tx_valid    = 1'b1;
								o.tx_byte     = desc_addr[m];
								o.bus_command = CMD_ACK;
							end
							TWS_MT_SLA_ACK: begin
								if (len != 0) begin
									o.tx_valid    = 1'b1;
									o.tx_byte     = tx_store[m * MAX_LEN];
									cur_byte      = LEN_W'(1);
									o.bus_command = CMD_ACK;
								end else begin
									advance_message(o);
								end
							end
							TWS_MT_DATA_ACK: begin
								if (int'(cur_byte) < len) begin
									o.tx_valid    = 1'b1;
									o.tx_byte     = tx_store[m * MAX_LEN + int'(cur_byte)];
									cur_byte++;
									o.bus_command = CMD_ACK;
								end else begin
									advance_message(o);
								end
							end
							TWS_MR_SLA_ACK: begin
								if (len != 0)
									o.bus_command = CMD_ACK;
								else
									advance_message(o);
							end
							TWS_MR_DATA_ACK: begin
								// A one-byte read acks its only byte, so the
								// message ends one byte late.
								take_byte(o, m, r.rx_data);
								if (len >= 1 && int'(cur_byte) == len - 1)
									o.bus_command = CMD_NACK;
								else if (int'(cur_byte) >= len)
									advance_message(o);
								else
									o.bus_command = CMD_ACK;
							end
							TWS_MR_DATA_NACK: begin
								take_byte(o, m, r.rx_data);
								if (int'(cur_byte) != len)
									close_transaction(o, TWS_MR_DATA_NACK);
								else
									advance_message(o);
							end
							TWS_ARB_LOST: begin
								cur_byte      = '0;
								cur_msg       = '0;
								o.bus_command = CMD_START;
							end
							default: begin
								close_transaction(o, r.status_code);
							end
						endcase
					end
				end
			endcase
			return o;
		endfunction

		function rsp_item_t note_request(req_item_t r);
			rsp_item_t want;
			want = predict_step(r);
			awaited.push_back(want);
			return want;
		endfunction

		task cmp_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s got %h expected %h", name, got, want));
		endtask

		task check_result(rsp_item_t got);
			rsp_item_t want;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing awaited", got));
			end else begin
				want = awaited.pop_front();
				cmp_field("bus_command", 8'(got.bus_command), 8'(want.bus_command));
				cmp_field("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
				cmp_field("tx_byte", got.tx_byte, want.tx_byte);
				cmp_field("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
				cmp_field("rx_msg", 8'(got.rx_msg), 8'(want.rx_msg));
				cmp_field("rx_index", 8'(got.rx_index), 8'(want.rx_index));
				cmp_field("rx_value", got.rx_value, want.rx_value);
				cmp_field("done_res", 8'(got.done_res), 8'(want.done_res));
				cmp_field("done_status", got.done_status, want.done_status);
				cmp_field("refused", 8'(got.refused), 8'(want.refused));
			end
		endtask

		task report_leftovers();
			if (awaited.size() != 0)
				report_mismatch($sformatf("%0d expected results never arrived",
					awaited.size()));
		endtask
	endclass

	// Where the simulated bus stands in the transaction, judged from the
	// last predicted command. It picks the status event a real bus would give.
	typedef enum {
		BP_IDLE,
		BP_WANT_START,
		BP_WANT_SLA,
		BP_WRITING,
		BP_READ_ACK,
		BP_READ_NACK
	} bus_phase_t;

	logic clk;
	logic arst_n;

	i2cts_req_if req_ch ();
	i2cts_rsp_if rsp_ch ();

	i2c_master_transaction_sequencer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	sequencer_scoreboard sb = new();

	bus_phase_t bus_phase = BP_IDLE;
	req_item_t  setup_q [$];
	int         sent = 0;
	int         src_idle_pct = 25;
	int         sink_idle_pct = 87;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Every field starts random, so bits a request does not use still toggle
	// and the sequencer must ignore them.
	function automatic req_item_t random_fields();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(req_item_t)-1:0];
	endfunction

	function automatic req_item_t desc_item(int slot, int addr, int len);
		req_item_t it;
		it = random_fields();
		it.action    = ACT_LOAD_DESC;
		it.msg_sel   = MSG_W'(slot);
		it.addr_byte = 8'(addr);
		it.msg_len   = LEN_W'(len);
		return it;
	endfunction

	function automatic req_item_t tx_item(int slot, int idx, int val);
		req_item_t it;
		it = random_fields();
		it.action    = ACT_LOAD_TX;
		it.msg_sel   = MSG_W'(slot);
		it.byte_sel  = BYTE_W'(idx);
		it.data_byte = 8'(val);
		return it;
	endfunction

	function automatic req_item_t begin_item(int cnt);
		req_item_t it;
		it = random_fields();
		it.action    = ACT_BEGIN;
		it.msg_count = MSG_CNT_W'(cnt);
		return it;
	endfunction

	function automatic req_item_t event_item(logic [7:0] code);
		req_item_t it;
		it = random_fields();
		it.action      = ACT_EVENT;
		it.status_code = code;
		return it;
	endfunction

	// Queues the loads and the begin of a fresh transaction. Most messages are
	// short; now and then all of them are full length.
	function automatic void plan_transaction();
		int n, len, cnt;
		bit long_run;
		n = $urandom_range(1, MAX_MSGS);
		long_run = ($urandom_range(99) < 6);
		for (int s = 0; s < n; s++) begin
			if (long_run || $urandom_range(99) < 70) begin
				if (long_run)
					len = MAX_LEN;
				else if ($urandom_range(99) < 90)
					len = $urandom_range(0, 4);
				else
					len = $urandom_range(0, 63);
				setup_q.push_back(desc_item(s, $urandom_range(255), len));
			end
			repeat ($urandom_range(0, 3))
				setup_q.push_back(tx_item($urandom_range(MAX_MSGS - 1),
					$urandom_range(MAX_LEN - 1), $urandom_range(255)));
		end
		cnt = ($urandom_range(99) < 85) ? n : $urandom_range(0, 7);
		setup_q.push_back(begin_item(cnt));
	endfunction

	function automatic req_item_t next_request();
		req_item_t it;
		int slot;
		it = random_fields();
		slot = int'(sb.cur_msg[MSG_W-1:0]);
		// A small share of pure noise: stray loads and begins, events in the
		// wrong place and codes the sequencer does not decode.
		if ($urandom_range(99) < 8) begin
			if (it.action == ACT_EVENT && $urandom_range(1) == 1) begin
				case ($urandom_range(7))
					0: it.status_code = TWS_BUS_ERROR;
					1: it.status_code = TWS_MT_SLA_NACK;
					2: it.status_code = TWS_MT_DATA_NACK;
					3: it.status_code = TWS_MR_SLA_NACK;
					4: it.status_code = TWS_ARB_LOST;
					5: it.status_code = TWS_MR_DATA_ACK;
					6: it.status_code = TWS_MT_DATA_ACK;
					default: it.status_code = TWS_START_LOWBIT;
				endcase
			end
			return it;
		end
		case (bus_phase)
			BP_IDLE: begin
				if (setup_q.size() == 0)
					plan_transaction();
				it = setup_q.pop_front();
			end
			BP_WANT_START: begin
				it = event_item(((sb.cur_msg == 0) ^ ($urandom_range(99) < 15))
					? TWS_START : TWS_REP_START);
			end
			BP_WANT_SLA: begin
				it = event_item(sb.desc_addr[slot][0] ? TWS_MR_SLA_ACK : TWS_MT_SLA_ACK);
			end
			BP_WRITING: begin
				it = event_item(($urandom_range(99) < 4) ? TWS_MT_DATA_NACK
					: TWS_MT_DATA_ACK);
			end
			BP_READ_ACK: begin
				// An early nack stops the transaction, but in a one-byte read it ends the message.
				it = event_item(($urandom_range(99) < 10) ? TWS_MR_DATA_NACK
					: TWS_MR_DATA_ACK);
			end
			default: begin
				// After a full-length read, an acked byte in place of the final nack still
				// fits the store and is reported at its last position.
				it = event_item((int'(sb.desc_len[slot]) == MAX_LEN && $urandom_range(1) == 1)
					? TWS_MR_DATA_ACK : TWS_MR_DATA_NACK);
			end
		endcase
		return it;
	endfunction

	function automatic void follow_result(req_item_t it, rsp_item_t want);
		if (want.done_res) begin
			bus_phase = BP_IDLE;
		end else begin
			case (want.bus_command)
				CMD_START: bus_phase = BP_WANT_START;
				CMD_ACK: begin
					if (!want.tx_valid)
						bus_phase = BP_READ_ACK;
					else if (it.status_code == TWS_START || it.status_code == TWS_REP_START)
						bus_phase = BP_WANT_SLA;
					else
						bus_phase = BP_WRITING;
				end
				CMD_NACK: bus_phase = BP_READ_NACK;
				default: ;
			endcase
		end
	endfunction

	// Offers one request and waits for its transfer. Valid stays high from one
	// request to the next unless an idle cycle is drawn in between.
	task automatic push_request(input req_item_t it);
		rsp_item_t want;
		if (sent < 700) begin
			src_idle_pct  = 25;
			sink_idle_pct = 87;
		end else if (sent < 1400) begin
			src_idle_pct  = 87;
			sink_idle_pct = 25;
		end else begin
			src_idle_pct  = 0;
			sink_idle_pct = 0;
		end
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= it;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		want = sb.note_request(it);
		follow_result(it, want);
		sent++;
	endtask

	// Result side: ready is redrawn every cycle and each completed transfer is
	// handed to the scoreboard.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (rsp_ch.valid && rsp_ch.ready)
					sb.check_result(rsp_ch.payload);
				rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	initial begin
		req_item_t it;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole descriptor table and transmit store first, so that
		// no later event reads an entry that was never written.
		for (int s = 0; s < MAX_MSGS; s++) begin
			push_request(desc_item(s, $urandom_range(255), $urandom_range(0, 4)));
			for (int b = 0; b < MAX_LEN; b++)
				push_request(tx_item(s, b, $urandom_range(255)));
		end

		// Directed part: an event while idle, length saturation, a refused
		// begin, arbitration loss, a write followed by a one-byte read, the
		// message count clamped at both ends, slave nack, bus error and a
		// status code with its low bits set.
		push_request(event_item(TWS_START));
		push_request(desc_item(0, 8'h00, 2));
		push_request(desc_item(1, 8'hFF, 1));
		push_request(desc_item(2, 8'h81, 63));
		push_request(tx_item(0, 0, 8'hFF));
		push_request(tx_item(MAX_MSGS - 1, MAX_LEN - 1, 8'h00));
		push_request(begin_item(2));
		push_request(begin_item(7));
		push_request(event_item(TWS_START));
		push_request(event_item(TWS_MT_SLA_ACK));
		push_request(event_item(TWS_ARB_LOST));
		push_request(event_item(TWS_START));
		push_request(event_item(TWS_MT_SLA_ACK));
		push_request(event_item(TWS_MT_DATA_ACK));
		push_request(event_item(TWS_MT_DATA_ACK));
		push_request(event_item(TWS_REP_START));
		push_request(event_item(TWS_MR_SLA_ACK));
		it = event_item(TWS_MR_DATA_ACK);
		it.rx_data = 8'hFF;
		push_request(it);
		push_request(begin_item(0));
		push_request(event_item(TWS_START));
		push_request(event_item(TWS_MT_SLA_NACK));
		push_request(begin_item(5));
		push_request(event_item(TWS_BUS_ERROR));
		push_request(begin_item(1));
		push_request(event_item(TWS_START_LOWBIT));

		// Random part: mostly bus-shaped transactions with random content.
		while (sent < TOTAL_ITEMS)
			push_request(next_request());
		req_ch.valid <= 1'b0;

		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		sb.report_leftovers();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog: a healthy run ends far sooner than this.
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

### sim.f
hdl/i2cts_pkg.sv
hdl/i2cts_req_if.sv
hdl/i2cts_rsp_if.sv
hdl/i2cts_ram.sv
hdl/i2cts_ctrl.sv
hdl/i2cts_dp.sv
hdl/i2c_master_transaction_sequencer.sv
sim/tb_i2c_master_transaction_sequencer.sv
